@@ rtl/gpsr_pkg.sv @@
package gpsr_pkg;

   typedef enum logic [1:0] {
      FUNC_TICK   = 2'd0,
      FUNC_BYTE   = 2'd1,
      FUNC_BUTTON = 2'd2,
      FUNC_UNUSED = 2'd3
   } func_type;

   typedef struct packed {
      logic       ack;
      logic       reply_valid;
      logic [7:0] reply_byte;
   } rsp_type;

   localparam logic [7:0] HEADER_START   = 8'h01;
   localparam logic [7:0] HEADER_POLL    = 8'h42;
   localparam logic [7:0] REPLY_ID       = 8'h41;
   localparam logic [7:0] REPLY_READY    = 8'h5a;
   localparam logic [7:0] TICKS_MAX      = 8'hff;
   localparam logic [7:0] GAP_LIMIT_INIT = 8'd2;

   localparam logic [2:0] POS_START    = 3'd0;
   localparam logic [2:0] POS_POLL     = 3'd1;
   localparam logic [2:0] POS_BTN_LOW  = 3'd2;
   localparam logic [2:0] POS_BTN_HIGH = 3'd3;
   localparam logic [2:0] POS_LAST     = 3'd4;

endpackage

@@ rtl/gpsr_core.sv @@
module gpsr_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              update,
   input  logic [1:0]        func,
   input  logic [7:0]        byte_value,
   input  logic [15:0]       button_word,
   input  logic [7:0]        gap_limit,
   output gpsr_pkg::rsp_type result
);
   import gpsr_pkg::*;

   logic [2:0]  position_ff, position_in;
   logic        muted_ff, muted_in;
   logic [7:0]  idle_ticks_ff, idle_ticks_in;
   logic [15:0] reply_word_ff, reply_word_in;

   logic        gap;
   logic [2:0]  pos_eff;
   logic        muted_eff;
   logic        bad;

   always_comb begin
      gap       = idle_ticks_ff > gap_limit;
      pos_eff   = gap ? POS_START : position_ff;
      muted_eff = gap ? 1'b0 : muted_ff;
      bad       = (pos_eff == POS_START && byte_value != HEADER_START) ||
                  (pos_eff == POS_POLL && byte_value != HEADER_POLL) ||
                  (pos_eff > POS_LAST);

      result.ack         = 1'b0;
      result.reply_valid = 1'b0;
      result.reply_byte  = 8'h00;
      if (!muted_eff && !bad) begin
         result.ack         = 1'b1;
         result.reply_valid = 1'b1;
         case (pos_eff)
            POS_START:    result.reply_byte = REPLY_ID;
            POS_POLL:     result.reply_byte = REPLY_READY;
            POS_BTN_LOW:  result.reply_byte = reply_word_ff[7:0];
            POS_BTN_HIGH: result.reply_byte = reply_word_ff[15:8];
            default:      result.reply_valid = 1'b0;
         endcase
      end

      position_in   = position_ff;
      muted_in      = muted_ff;
      idle_ticks_in = idle_ticks_ff;
      reply_word_in = reply_word_ff;
      case (func_type'(func))
         FUNC_TICK: begin
            if (idle_ticks_ff != TICKS_MAX) begin
               idle_ticks_in = idle_ticks_ff + 8'd1;
            end
         end
         FUNC_BYTE: begin
            idle_ticks_in = 8'd0;
            muted_in      = muted_eff || bad;
            position_in   = (muted_eff || bad) ? pos_eff : pos_eff + 3'd1;
         end
         FUNC_BUTTON: begin
            reply_word_in = ~button_word;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff   <= POS_START;
         muted_ff      <= 1'b0;
         idle_ticks_ff <= 8'd0;
         reply_word_ff <= 16'h0000;
      end else if (update) begin
         position_ff   <= position_in;
         muted_ff      <= muted_in;
         idle_ticks_ff <= idle_ticks_in;
         reply_word_ff <= reply_word_in;
      end
   end

endmodule

@@ rtl/game_pad_serial_responder_top.sv @@
// Device side of a game-pad serial poll. Each request transfer is a
// millisecond tick, a byte received from the console, or a new button
// word; only a received byte produces a response transfer, carrying the
// acknowledge flag and the byte to load for the next serial exchange. One
// request is taken per clock cycle, save that a byte waits in the input
// register until the response register is empty or being drained. A
// request sits in an input register, the protocol step runs in one pass
// of logic, and the response lands in an output register. The user must
// write the gap limit via csr only while idle; it is not enforced.
module game_pad_serial_responder_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [7:0]  req_byte_value,
   input  logic [15:0] req_button_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_ack,
   output logic        rsp_reply_valid,
   output logic [7:0]  rsp_reply_byte,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_gap_limit
);
   import gpsr_pkg::*;

   logic        in_valid_ff;
   logic [1:0]  in_func_ff;
   logic [7:0]  in_byte_ff;
   logic [15:0] in_button_ff;
   logic [7:0]  gap_limit_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff;
   rsp_type     result;
   logic        is_byte;
   logic        advance;

   assign is_byte   = in_func_ff == FUNC_BYTE;
   assign advance   = in_valid_ff && (!is_byte || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   gpsr_core u_core (
      .clock       (clock),
      .reset       (reset),
      .update      (advance),
      .func        (in_func_ff),
      .byte_value  (in_byte_ff),
      .button_word (in_button_ff),
      .gap_limit   (gap_limit_ff),
      .result      (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (advance && is_byte) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         gap_limit_ff <= GAP_LIMIT_INIT;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            gap_limit_ff <= csr_gap_limit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_func_ff   <= req_func;
         in_byte_ff   <= req_byte_value;
         in_button_ff <= req_button_word;
      end
      if (advance && is_byte) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ack         = rsp_ff.ack;
   assign rsp_reply_valid = rsp_ff.reply_valid;
   assign rsp_reply_byte  = rsp_ff.reply_byte;

   // A reply is only ever loaded for an acknowledged byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.reply_valid |-> rsp_ff.ack)
      else $error("reply loaded on a NAK");

   // A NAK or an acknowledge without reply carries a zero byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.reply_valid |-> rsp_ff.reply_byte == 8'h00)
      else $error("reply byte not cleared");

   // A held request that cannot advance stays in the input register.
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_func_ff))
      else $error("stalled request lost");

   // Ticks and button words never create a response transfer.
   assert property (@(posedge clock) disable iff (reset)
      advance && !is_byte |=> rsp_valid_ff == $past(rsp_valid_ff && !rsp_ready))
      else $error("response created by a non-byte request");

endmodule
